/* hdl/sha1_pkg.sv */
// sha1_pkg: shared types and constants of the sha-1 byte stream hasher
// holds the sequencer state type, the working variable struct and the round constants
// no dependencies
`default_nettype none

package sha1_pkg;

  // message block geometry
  localparam int unsigned BlockBits = 512;
  localparam int unsigned WordBits  = 32;
  localparam int unsigned ByteBits  = 8;
  localparam int unsigned NumWords  = 5;

  // positions inside one 64-byte block
  localparam logic [5:0] BlockLastPos = 6'd63;
  localparam logic [5:0] LengthPos    = 6'd56;

  // compression rounds
  localparam logic [6:0] RoundLast = 7'd79;
  localparam logic [6:0] Round20   = 7'd20;
  localparam logic [6:0] Round40   = 7'd40;
  localparam logic [6:0] Round60   = 7'd60;

  // digest word positions
  localparam logic [2:0] WordFirst = 3'd0;
  localparam logic [2:0] WordLast  = 3'd4;

  // round constants
  localparam logic [31:0] K0 = 32'h5A827999;
  localparam logic [31:0] K1 = 32'h6ED9EBA1;
  localparam logic [31:0] K2 = 32'h8F1BBCDC;
  localparam logic [31:0] K3 = 32'hCA62C1D6;

  // initial chaining values
  localparam logic [31:0] HInit [NumWords] = '{
    32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
  };

  // padding bytes: the leading mark and the zero fill
  localparam logic [7:0] PadMark = 8'h80;
  localparam logic [7:0] PadZero = 8'h00;

  // sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_PAD_MARK,
    S_PAD_ZERO,
    S_PAD_LEN,
    S_ROUND,
    S_ADD,
    S_OUT
  } state_e;

  // working variables of one compression
  typedef struct packed {
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
    logic [31:0] d;
    logic [31:0] e;
  } work_t;

endpackage

`default_nettype wire

/* hdl/sha1_if.sv */
// sha1_if: valid/ready channels of the sha-1 byte stream hasher
// sha1_msg_if carries message bytes, sha1_dig_if carries digest words; no dependencies
`default_nettype none

interface sha1_msg_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       byte_valid;
  logic       end_of_message;

  modport source (output valid, output data_byte, output byte_valid,
                  output end_of_message, input ready);
  modport sink   (input valid, input data_byte, input byte_valid,
                  input end_of_message, output ready);
endinterface

interface sha1_dig_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        last_word;

  modport source (output valid, output digest_word, output word_index,
                  output last_word, input ready);
  modport sink   (input valid, input digest_word, input word_index,
                  input last_word, output ready);
endinterface

`default_nettype wire

/* hdl/sha1_round.sv */
// sha1_round: one sha-1 compression round, shared by all 80 rounds
// depends on sha1_pkg for the work_t struct and the round constants
`default_nettype none

module sha1_round (
  input  sha1_pkg::work_t cur_i,
  input  logic [31:0]     w_i,
  input  logic [6:0]      rnd_i,
  output sha1_pkg::work_t nxt_o
);

  logic [31:0] f;
  logic [31:0] k;

  // round function and constant by round group
  always_comb begin
    priority if (rnd_i < sha1_pkg::Round20) begin
      f = (cur_i.b & cur_i.c) | (~cur_i.b & cur_i.d);
      k = sha1_pkg::K0;
    end else if (rnd_i < sha1_pkg::Round40) begin
      f = cur_i.b ^ cur_i.c ^ cur_i.d;
      k = sha1_pkg::K1;
    end else if (rnd_i < sha1_pkg::Round60) begin
      f = (cur_i.b & cur_i.c) | (cur_i.b & cur_i.d) | (cur_i.c & cur_i.d);
      k = sha1_pkg::K2;
    end else begin
      f = cur_i.b ^ cur_i.c ^ cur_i.d;
      k = sha1_pkg::K3;
    end
  end

  // rotate the working variables
  always_comb begin
    nxt_o.a = {cur_i.a[26:0], cur_i.a[31:27]} + f + cur_i.e + k + w_i;
    nxt_o.b = cur_i.a;
    nxt_o.c = {cur_i.b[1:0], cur_i.b[31:2]};
    nxt_o.d = cur_i.c;
    nxt_o.e = cur_i.d;
  end

endmodule

`default_nettype wire

/* hdl/sha1_byte_stream_hasher.sv */
// sha1_byte_stream_hasher: sha-1 over a stream of message bytes, digest as five words
// depends on sha1_pkg, the channels in sha1_if and the round unit sha1_round
//
// A message byte is taken from each accepted request whose byte_valid is set. Each 64th
// byte starts a compression that holds the input off: 80 rounds through one shared round
// unit, one per cycle, then a fold of the result into the chaining values. The message
// schedule is a 512-bit shift line that first collects the bytes and then rolls one word
// per round. An end-of-message request pads one byte per cycle outside compressions (the
// 0x80 mark, zeros up to byte 56, then eight length bytes), compressing one or two final
// blocks. The five digest words then go out H0 first, one per accepted output request,
// after which the chaining values and the byte count restart for the next message. Input
// is accepted only while the block is idle; no clearing pass follows reset.
`default_nettype none

module sha1_byte_stream_hasher (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  sha1_msg_if.sink     msg_i,
  sha1_dig_if.source   dig_o
);

  sha1_pkg::state_e state_q, state_d;
  sha1_pkg::state_e ret_q, ret_d;

  logic [511:0] buf_q, buf_d;
  logic [5:0]   pos_q, pos_d;
  logic [60:0]  count_q, count_d;
  logic [63:0]  len_q, len_d;
  logic [6:0]   rnd_q, rnd_d;
  logic [2:0]   idx_q, idx_d;
  logic [31:0]  chain_q [sha1_pkg::NumWords];
  logic [31:0]  chain_d [sha1_pkg::NumWords];

  sha1_pkg::work_t work_q, work_d, work_nxt;

  logic             byte_put;
  logic [7:0]       byte_val;
  sha1_pkg::state_e after_put;
  sha1_pkg::state_e ret_put;
  logic [31:0]      w_cur;
  logic [31:0]      w_mix;
  logic [31:0]      w_new;

  // schedule taps: oldest word first
  assign w_cur = buf_q[511:480];
  assign w_mix = buf_q[95:64] ^ buf_q[255:224] ^ buf_q[447:416] ^ w_cur;
  assign w_new = {w_mix[30:0], w_mix[31]};

  sha1_round u_round (
    .cur_i (work_q),
    .w_i   (w_cur),
    .rnd_i (rnd_q),
    .nxt_o (work_nxt)
  );

  // handshake and output words
  assign msg_i.ready       = (state_q == sha1_pkg::S_IDLE);
  assign dig_o.valid       = (state_q == sha1_pkg::S_OUT);
  assign dig_o.digest_word = chain_q[idx_q];
  assign dig_o.word_index  = idx_q;
  assign dig_o.last_word   = (idx_q == sha1_pkg::WordLast);

  // sequencer registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sha1_pkg::S_IDLE;
      ret_q   <= sha1_pkg::S_IDLE;
      pos_q   <= '0;
      count_q <= '0;
      rnd_q   <= '0;
      idx_q   <= sha1_pkg::WordFirst;
      for (int i = 0; i < sha1_pkg::NumWords; i++) begin
        chain_q[i] <= sha1_pkg::HInit[i];
      end
    end else begin
      state_q <= state_d;
      ret_q   <= ret_d;
      pos_q   <= pos_d;
      count_q <= count_d;
      rnd_q   <= rnd_d;
      idx_q   <= idx_d;
      for (int i = 0; i < sha1_pkg::NumWords; i++) begin
        chain_q[i] <= chain_d[i];
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    buf_q  <= buf_d;
    len_q  <= len_d;
    work_q <= work_d;
  end

  // next state and datapath
  always_comb begin
    state_d   = state_q;
    ret_d     = ret_q;
    buf_d     = buf_q;
    pos_d     = pos_q;
    count_d   = count_q;
    len_d     = len_q;
    rnd_d     = rnd_q;
    idx_d     = idx_q;
    work_d    = work_q;
    chain_d   = chain_q;
    byte_put  = 1'b0;
    byte_val  = sha1_pkg::PadZero;
    after_put = state_q;
    ret_put   = sha1_pkg::S_IDLE;

    unique case (state_q)
      sha1_pkg::S_IDLE: begin
        if (msg_i.valid) begin
          if (msg_i.byte_valid) begin
            byte_put  = 1'b1;
            byte_val  = msg_i.data_byte;
            count_d   = count_q + 61'd1;
          end
          after_put = msg_i.end_of_message ? sha1_pkg::S_PAD_MARK : sha1_pkg::S_IDLE;
          ret_put   = after_put;
          state_d   = after_put;
        end
      end
      sha1_pkg::S_PAD_MARK: begin
        byte_put  = 1'b1;
        byte_val  = sha1_pkg::PadMark;
        len_d     = {count_q, 3'b000};
        after_put = sha1_pkg::S_PAD_ZERO;
        ret_put   = sha1_pkg::S_PAD_ZERO;
      end
      sha1_pkg::S_PAD_ZERO: begin
        if (pos_q == sha1_pkg::LengthPos) begin
          state_d = sha1_pkg::S_PAD_LEN;
        end else begin
          byte_put  = 1'b1;
          after_put = sha1_pkg::S_PAD_ZERO;
          ret_put   = sha1_pkg::S_PAD_ZERO;
        end
      end
      sha1_pkg::S_PAD_LEN: begin
        byte_put  = 1'b1;
        byte_val  = len_q[63:56];
        len_d     = {len_q[55:0], 8'h00};
        after_put = sha1_pkg::S_PAD_LEN;
        ret_put   = sha1_pkg::S_OUT;
      end
      sha1_pkg::S_ROUND: begin
        work_d = work_nxt;
        buf_d  = {buf_q[479:0], w_new};
        rnd_d  = rnd_q + 7'd1;
        if (rnd_q == sha1_pkg::RoundLast) begin
          state_d = sha1_pkg::S_ADD;
        end
      end
      sha1_pkg::S_ADD: begin
        chain_d[0] = chain_q[0] + work_q.a;
        chain_d[1] = chain_q[1] + work_q.b;
        chain_d[2] = chain_q[2] + work_q.c;
        chain_d[3] = chain_q[3] + work_q.d;
        chain_d[4] = chain_q[4] + work_q.e;
        state_d    = ret_q;
      end
      sha1_pkg::S_OUT: begin
        if (dig_o.ready) begin
          if (idx_q == sha1_pkg::WordLast) begin
            idx_d   = sha1_pkg::WordFirst;
            count_d = '0;
            state_d = sha1_pkg::S_IDLE;
            for (int i = 0; i < sha1_pkg::NumWords; i++) begin
              chain_d[i] = sha1_pkg::HInit[i];
            end
          end else begin
            idx_d = idx_q + 3'd1;
          end
        end
      end
      default: begin
        state_d = sha1_pkg::S_IDLE;
      end
    endcase

    // shift a byte into the block, start a compression on the last one
    if (byte_put) begin
      buf_d = {buf_q[503:0], byte_val};
      pos_d = pos_q + 6'd1;
      if (pos_q == sha1_pkg::BlockLastPos) begin
        state_d = sha1_pkg::S_ROUND;
        ret_d   = ret_put;
        rnd_d   = '0;
        work_d  = '{a: chain_q[0], b: chain_q[1], c: chain_q[2],
                    d: chain_q[3], e: chain_q[4]};
      end else begin
        state_d = after_put;
      end
    end
  end

`ifndef SYNTHESIS
  // no input request is taken while digest words are pending
  a_no_input_during_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    msg_i.ready |-> !dig_o.valid)
    else $error("input ready while digest output pending");

  // the last digest word hands back to idle
  a_idle_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (dig_o.valid && dig_o.ready && dig_o.last_word) |=> msg_i.ready)
    else $error("block not idle after last digest word");

  // round counter never passes the last round
  a_round_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == sha1_pkg::S_ROUND) |-> (rnd_q <= sha1_pkg::RoundLast))
    else $error("round counter out of range");

  // rounds advance one per cycle until the last
  a_round_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == sha1_pkg::S_ROUND && rnd_q != sha1_pkg::RoundLast)
      |=> (state_q == sha1_pkg::S_ROUND && rnd_q == 7'($past(rnd_q) + 7'd1)))
    else $error("compression rounds did not advance");

  // a compression always ends with the fold into the chaining values
  a_add_after_round: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == sha1_pkg::S_ROUND && rnd_q == sha1_pkg::RoundLast)
      |=> (state_q == sha1_pkg::S_ADD))
    else $error("missing chaining value update");
`endif

endmodule

`default_nettype wire

/* test/sha1_byte_stream_hasher_tb.sv */
`timescale 1ns / 100ps
// sha1_byte_stream_hasher_tb: self-checking bench for the sha-1 byte stream hasher
// drives message bytes, predicts the digest words in place and compares every output request
// depends on sha1_if (sha1_msg_if, sha1_dig_if) and the top level sha1_byte_stream_hasher

module sha1_byte_stream_hasher_tb;

  // digest as 160 bits, H0 in the top word
  typedef logic [159:0] digest_t;

  // one digest word as it should come out
  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  idx;
    logic        is_last;
  } digest_beat_t;

  // one row of the directed table
  typedef struct packed {
    logic [7:0] data;
    logic       bv;
    logic       eom;
    logic       has_known;
    digest_t    known;
  } stim_row_t;

  localparam int      DirRows   = 17;
  localparam int      LongHold  = 300;
  localparam int      RandItems = 80;
  localparam int      MinMsgs   = 3;
  localparam digest_t DigestEmpty = 160'hda39a3ee_5e6b4b0d_3255bfef_95601890_afd80709;
  localparam digest_t DigestAbc   = 160'ha9993e36_4706816a_ba3e2571_7850c26c_9cd0d89d;

  localparam logic [31:0] ChainInit [5] = '{
    32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
  };
  localparam logic [31:0] RoundK [4] = '{
    32'h5A827999, 32'h6ED9EBA1, 32'h8F1BBCDC, 32'hCA62C1D6
  };

  logic clk_i;
  logic rst_ni;

  sha1_msg_if msg_if ();
  sha1_dig_if dig_if ();

  sha1_byte_stream_hasher uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .msg_i  (msg_if),
    .dig_o  (dig_if)
  );

  // predictor state
  logic [31:0]  chain_q [5];
  logic [7:0]   blk_q [64];
  logic [60:0]  nbytes_q;

  digest_beat_t pending_digest_q [$];
  int           mismatch_count;
  bit           tx_steady;
  bit           pressure_arm;

  // directed table: idle items, empty message, "abc", extreme bytes, back-to-back ends
  stim_row_t dir_table [DirRows] = '{
    '{8'h00, 1'b0, 1'b0, 1'b0, '0},
    '{8'hFF, 1'b0, 1'b0, 1'b0, '0},
    '{8'hA5, 1'b0, 1'b1, 1'b1, DigestEmpty},
    '{8'h61, 1'b1, 1'b0, 1'b0, '0},
    '{8'h5A, 1'b0, 1'b0, 1'b0, '0},
    '{8'h62, 1'b1, 1'b0, 1'b0, '0},
    '{8'h63, 1'b1, 1'b1, 1'b1, DigestAbc},
    '{8'h00, 1'b1, 1'b1, 1'b0, '0},
    '{8'hFF, 1'b1, 1'b0, 1'b0, '0},
    '{8'h00, 1'b1, 1'b0, 1'b0, '0},
    '{8'h80, 1'b1, 1'b0, 1'b0, '0},
    '{8'h7F, 1'b1, 1'b0, 1'b0, '0},
    '{8'h01, 1'b1, 1'b0, 1'b0, '0},
    '{8'hFE, 1'b1, 1'b0, 1'b0, '0},
    '{8'hFF, 1'b0, 1'b1, 1'b0, '0},
    '{8'h00, 1'b0, 1'b1, 1'b1, DigestEmpty},
    '{8'hFF, 1'b1, 1'b1, 1'b0, '0}
  };

  // message lengths around the one/two padding block boundaries
  int boundary_len [9] = '{54, 55, 56, 57, 63, 64, 65, 119, 120};

  // clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // run limit
  initial begin
    #2000000;
    $display("FAIL sha1_byte_stream_hasher");
    $finish;
  end

  function automatic logic [31:0] rotl(input logic [31:0] x, input int n);
    return (x << n) | (x >> (32 - n));
  endfunction

  // 80-round compression of blk_q into chain_q
  function automatic void sha_compress();
    logic [31:0] w [16];
    logic [31:0] a, b, c, d, e, f, t;
    int s;
    for (int k = 0; k < 16; k++)
      w[k] = {blk_q[4*k], blk_q[4*k+1], blk_q[4*k+2], blk_q[4*k+3]};
    a = chain_q[0]; b = chain_q[1]; c = chain_q[2]; d = chain_q[3]; e = chain_q[4];
    for (int r = 0; r < 80; r++) begin
      s = r % 16;
      if (r >= 16)
        w[s] = rotl(w[(s+13)%16] ^ w[(s+8)%16] ^ w[(s+2)%16] ^ w[s], 1);
      if (r < 20)      f = (b & c) | (~b & d);
      else if (r < 40) f = b ^ c ^ d;
      else if (r < 60) f = (b & c) | (b & d) | (c & d);
      else             f = b ^ c ^ d;
      t = rotl(a, 5) + f + e + RoundK[r/20] + w[s];
      e = d; d = c; c = rotl(b, 30); b = a; a = t;
    end
    chain_q[0] += a; chain_q[1] += b; chain_q[2] += c; chain_q[3] += d; chain_q[4] += e;
  endfunction

  function automatic void hash_byte(input logic [7:0] v);
    int pos;
    pos = int'(nbytes_q[5:0]);
    blk_q[pos] = v;
    nbytes_q = nbytes_q + 61'd1;
    if (pos == 63) sha_compress();
  endfunction

  // advance the predicted hasher by one request; returns 1 when a digest is due
  function automatic bit sha1_predict_step(input logic [7:0] d, input logic bv,
                                           input logic eom, output digest_t dig);
    logic [63:0] nbits;
    int pos;
    dig = '0;
    if (bv) hash_byte(d);
    if (!eom) return 1'b0;
    nbits = {nbytes_q, 3'b000};
    pos = int'(nbytes_q[5:0]);
    blk_q[pos] = 8'h80;
    pos++;
    // no room for the length: finish this block, length goes in the next
    if (pos > 56) begin
      while (pos < 64) begin
        blk_q[pos] = 8'h00;
        pos++;
      end
      sha_compress();
      pos = 0;
    end
    while (pos < 56) begin
      blk_q[pos] = 8'h00;
      pos++;
    end
    for (int i = 0; i < 8; i++) blk_q[56+i] = nbits[63-8*i -: 8];
    sha_compress();
    dig = {chain_q[0], chain_q[1], chain_q[2], chain_q[3], chain_q[4]};
    for (int i = 0; i < 5; i++) chain_q[i] = ChainInit[i];
    nbytes_q = '0;
    return 1'b1;
  endfunction

  // mostly short gaps, a few long ones, none in a steady stretch
  function automatic int pick_gap(input bit steady);
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
    $display("%0t mismatch %s: expected %h got %h", $time, what, want, got);
    mismatch_count++;
  endtask

  // offer one request from a falling edge, wait for it to be taken, then idle for a random gap, which may be none
  task automatic send_req(input logic [7:0] d, input logic bv, input logic eom,
                          input logic has_known, input digest_t known);
    digest_t dig;
    int gap;
    msg_if.valid          <= 1'b1;
    msg_if.data_byte      <= d;
    msg_if.byte_valid     <= bv;
    msg_if.end_of_message <= eom;
    @(posedge clk_i);
    while (!msg_if.ready) @(posedge clk_i);
    if (sha1_predict_step(d, bv, eom, dig)) begin
      if (has_known) dig = known;
      for (int i = 0; i < 5; i++)
        pending_digest_q.push_back('{dig[159-32*i -: 32], 3'(i), i == 4});
    end
    @(negedge clk_i);
    gap = pick_gap(tx_steady);
    if (gap > 0) begin
      msg_if.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
  endtask

  // compare each accepted digest word with the oldest prediction
  always @(posedge clk_i) begin : digest_check
    digest_beat_t want;
    if (rst_ni && dig_if.valid && dig_if.ready) begin
      if (pending_digest_q.size() == 0) begin
        report_mismatch("unexpected digest word", '0, dig_if.digest_word);
      end else begin
        want = pending_digest_q.pop_front();
        if (dig_if.digest_word !== want.word)
          report_mismatch("digest_word", want.word, dig_if.digest_word);
        if (dig_if.word_index !== want.idx)
          report_mismatch("word_index", 32'(want.idx), 32'(dig_if.word_index));
        if (dig_if.last_word !== want.is_last)
          report_mismatch("last_word", 32'(want.is_last), 32'(dig_if.last_word));
      end
    end
  end

  // output side: random stalls, steady stretches, one long hold-off under load
  initial begin : digest_drain
    int stall_left;
    bit steady;
    stall_left = 0;
    steady = 1'b0;
    dig_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if ($urandom_range(0, 63) == 0) steady = ~steady;
      if (stall_left > 0) begin
        dig_if.ready <= 1'b0;
        stall_left--;
      end else if (pressure_arm && dig_if.valid) begin
        pressure_arm = 1'b0;
        stall_left = LongHold - 1;
        dig_if.ready <= 1'b0;
      end else begin
        stall_left = pick_gap(steady);
        if (stall_left > 0) begin
          dig_if.ready <= 1'b0;
          stall_left--;
        end else begin
          dig_if.ready <= 1'b1;
        end
      end
    end
  end

  // stimulus
  initial begin : stimulus
    int rand_items;
    int msg_count;
    int len;
    bit ended;
    rst_ni                = 1'b0;
    msg_if.valid          = 1'b0;
    msg_if.data_byte      = '0;
    msg_if.byte_valid     = 1'b0;
    msg_if.end_of_message = 1'b0;
    mismatch_count        = 0;
    tx_steady             = 1'b0;
    pressure_arm          = 1'b0;
    nbytes_q              = '0;
    for (int i = 0; i < 5; i++) chain_q[i] = ChainInit[i];
    for (int i = 0; i < 64; i++) blk_q[i] = 8'h00;
    rand_items = 0;
    msg_count  = 0;

    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed table
    for (int i = 0; i < DirRows; i++)
      send_req(dir_table[i].data, dir_table[i].bv, dir_table[i].eom,
               dir_table[i].has_known, dir_table[i].known);

    // random messages: mostly short, some at the padding boundaries, idle items mixed in
    pressure_arm = 1'b1;
    while (rand_items < RandItems || msg_count < MinMsgs) begin
      if ($urandom_range(0, 9) < 7) len = $urandom_range(0, 15);
      else len = boundary_len[$urandom_range(0, 8)];
      tx_steady = ($urandom_range(0, 3) == 0);
      ended = 1'b0;
      for (int j = 0; j < len; j++) begin
        if ($urandom_range(0, 7) == 0)
          send_req(8'($urandom_range(0, 255)), 1'b0, 1'b0, 1'b0, '0);
        if (j == len - 1 && $urandom_range(0, 1) == 1) begin
          send_req(8'($urandom_range(0, 255)), 1'b1, 1'b1, 1'b0, '0);
          ended = 1'b1;
        end else begin
          send_req(8'($urandom_range(0, 255)), 1'b1, 1'b0, 1'b0, '0);
        end
        rand_items++;
      end
      if (!ended) begin
        send_req(8'($urandom_range(0, 255)), 1'b0, 1'b1, 1'b0, '0);
        rand_items++;
      end
      msg_count++;
    end
    msg_if.valid <= 1'b0;

    // drain, then watch for stray output
    while (pending_digest_q.size() != 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);
    if (mismatch_count == 0) $display("PASS sha1_byte_stream_hasher");
    else $display("FAIL sha1_byte_stream_hasher");
    $finish;
  end

endmodule
